// ===== rtl/lwpb_pkg.sv =====
// ----------------------------------------------------------------------------
// lwpb_pkg
// Shared types and codes of the write-back page buffer.
// ----------------------------------------------------------------------------
package lwpb_pkg;

    localparam int IDX_W  = 15;  // byte index width
    localparam int DATA_W = 8;   // byte width
    localparam int CFG_W  = 16;  // array_size register width

    localparam logic [CFG_W-1:0] ARRAY_SIZE_RESET = 16'd32768;

    // request kinds (input tuser)
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // result status (output tuser)
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITEBACK,
        ST_FILL,
        ST_ACCESS,
        ST_RESPOND
    } t_state;

endpackage

// ===== rtl/lru_writeback_page_buffer.sv =====
// ----------------------------------------------------------------------------
// lru_writeback_page_buffer
// Byte array in a backing store, fronted by a fully associative set of page
// frames with exact LRU replacement and write-back of dirty frames.
// ----------------------------------------------------------------------------
// One request is handled at a time. A hit accesses the frame memory at the
// input transfer, then a hit or out-of-range result waits in the respond
// state until the result register is free. A miss writes back a dirty victim
// frame, fills the frame from the backing store and then accesses it; the
// byte-wide page copies between the frame memory and the backing store run
// one byte per cycle through their single read and write ports. The backing
// store needs no clearing pass: a flag per page marks pages that were ever
// written back, and a page without it reads as zeros. PAGE_BYTES and
// NUM_PAGES must be powers of two; the block does not enforce it. The result
// register lets a new request be taken while the last result awaits transfer.
// ----------------------------------------------------------------------------
module lru_writeback_page_buffer #(
    parameter int PAGE_BYTES = 512,
    parameter int NUM_FRAMES = 3,
    parameter int NUM_PAGES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: array_size
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // requests
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [14:0] index, [22:15] write_data, [23] zero
    input  logic [0:0]  i_s_axis_tuser,   // [0] req_type
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] read_data, [8] was_hit, [15:9] zero
    output logic [0:0]  o_m_axis_tuser    // [0] status
);

    localparam int OFF_W    = $clog2(PAGE_BYTES);
    localparam int CNT_W    = OFF_W + 1;
    localparam int FRAME_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int REC_W    = FRAME_W;
    localparam int PAGE_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int FRM_AW   = FRAME_W + OFF_W;
    localparam int STORE_AW = PAGE_W + OFF_W;
    localparam int FRM_DEPTH   = NUM_FRAMES * PAGE_BYTES;
    localparam int STORE_DEPTH = NUM_PAGES * PAGE_BYTES;
    localparam int IDX_W  = lwpb_pkg::IDX_W;
    localparam int DATA_W = lwpb_pkg::DATA_W;

    // memories
    logic [DATA_W-1:0] mem_frame [FRM_DEPTH];
    logic [DATA_W-1:0] mem_store [STORE_DEPTH];

    // control state
    lwpb_pkg::t_state r_state, n_state;
    logic [lwpb_pkg::CFG_W-1:0] r_array_size;
    logic [NUM_FRAMES-1:0] r_valid, n_valid;
    logic [NUM_FRAMES-1:0] r_dirty, n_dirty;
    logic [REC_W-1:0]      r_recency [NUM_FRAMES];
    logic [REC_W-1:0]      n_recency [NUM_FRAMES];
    logic [PAGE_W-1:0]     r_fpage   [NUM_FRAMES];
    logic [PAGE_W-1:0]     n_fpage   [NUM_FRAMES];
    logic [NUM_PAGES-1:0]  r_page_written;
    logic [CNT_W-1:0]      r_count;
    logic                  r_lag_valid;
    logic                  r_out_valid;

    // request payload
    logic                  r_req_write;
    logic [OFF_W-1:0]      r_offset;
    logic [PAGE_W-1:0]     r_page;
    logic [DATA_W-1:0]     r_wdata;
    logic [FRAME_W-1:0]    r_frame;
    logic [PAGE_W-1:0]     r_victim_page;
    logic                  r_status;
    logic                  r_hit;
    logic [OFF_W-1:0]      r_lag_off;
    logic [DATA_W-1:0]     r_frame_rdata;
    logic [DATA_W-1:0]     r_store_rdata;
    logic [15:0]           r_out_data;
    logic                  r_out_status;

    // request decode
    logic                  acc;
    logic [IDX_W-1:0]      in_index;
    logic [IDX_W-1:0]      in_page_raw;
    logic [DATA_W-1:0]     in_wdata;
    logic                  in_write;
    logic                  in_err;
    logic [PAGE_W-1:0]     in_page;
    logic [OFF_W-1:0]      in_offset;
    logic                  hit_any;
    logic [FRAME_W-1:0]    hit_f;
    logic                  free_any;
    logic [FRAME_W-1:0]    free_f;
    logic [FRAME_W-1:0]    lru_f;
    logic [FRAME_W-1:0]    pick_f;
    logic                  victim_wb;
    logic                  count_done;
    logic                  out_free;
    logic [DATA_W-1:0]     fill_byte;
    logic [DATA_W-1:0]     resp_rdata;

    // memory ports
    logic                  frm_we, frm_re;
    logic [FRM_AW-1:0]     frm_addr;
    logic [DATA_W-1:0]     frm_wdata;
    logic                  st_we, st_re;
    logic [STORE_AW-1:0]   st_waddr, st_raddr;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == lwpb_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

    assign count_done = (r_count == CNT_W'(PAGE_BYTES));
    assign out_free   = !r_out_valid || i_m_axis_tready;
    // pages never written back read as zeros
    assign fill_byte  = r_page_written[r_page] ? r_store_rdata : '0;

    // lookup and victim choice
    always_comb begin
        acc         = i_s_axis_tvalid && (r_state == lwpb_pkg::ST_IDLE);
        in_index    = i_s_axis_tdata[IDX_W-1:0];
        in_wdata    = i_s_axis_tdata[IDX_W+DATA_W-1:IDX_W];
        in_write    = (i_s_axis_tuser[0] == lwpb_pkg::REQ_WRITE);
        in_err      = {1'b0, in_index} >= r_array_size;
        in_page_raw = in_index >> OFF_W;
        in_page     = PAGE_W'(in_page_raw % IDX_W'(NUM_PAGES));
        in_offset   = in_index[OFF_W-1:0];

        // lowest matching frame wins
        hit_any = 1'b0;
        hit_f   = '0;
        for (int g = NUM_FRAMES - 1; g >= 0; g--) begin
            if (r_valid[g] && (r_fpage[g] == in_page)) begin
                hit_any = 1'b1;
                hit_f   = FRAME_W'(g);
            end
        end

        free_any = 1'b0;
        free_f   = '0;
        for (int g = NUM_FRAMES - 1; g >= 0; g--) begin
            if (!r_valid[g]) begin
                free_any = 1'b1;
                free_f   = FRAME_W'(g);
            end
        end

        // first frame with the oldest rank
        lru_f = '0;
        for (int g = 1; g < NUM_FRAMES; g++) begin
            if (r_recency[g] > r_recency[lru_f]) begin
                lru_f = FRAME_W'(g);
            end
        end

        pick_f    = free_any ? free_f : lru_f;
        victim_wb = r_valid[pick_f] && r_dirty[pick_f];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lwpb_pkg::ST_IDLE: begin
                if (acc) begin
                    if (in_err || hit_any) begin
                        n_state = lwpb_pkg::ST_RESPOND;
                    end else if (victim_wb) begin
                        n_state = lwpb_pkg::ST_WRITEBACK;
                    end else begin
                        n_state = lwpb_pkg::ST_FILL;
                    end
                end
            end
            lwpb_pkg::ST_WRITEBACK: begin
                if (count_done) begin
                    n_state = lwpb_pkg::ST_FILL;
                end
            end
            lwpb_pkg::ST_FILL: begin
                if (count_done) begin
                    n_state = lwpb_pkg::ST_ACCESS;
                end
            end
            lwpb_pkg::ST_ACCESS: begin
                n_state = lwpb_pkg::ST_RESPOND;
            end
            lwpb_pkg::ST_RESPOND: begin
                if (out_free) begin
                    n_state = lwpb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lwpb_pkg::ST_IDLE;
            end
        endcase
    end

    // memory port control
    always_comb begin
        frm_we    = 1'b0;
        frm_re    = 1'b0;
        frm_addr  = {r_frame, r_offset};
        frm_wdata = r_wdata;
        unique case (r_state)
            lwpb_pkg::ST_IDLE: begin
                if (acc && !in_err && hit_any) begin
                    frm_addr  = {hit_f, in_offset};
                    frm_we    = in_write;
                    frm_re    = !in_write;
                    frm_wdata = in_wdata;
                end
            end
            lwpb_pkg::ST_WRITEBACK: begin
                frm_re   = !count_done;
                frm_addr = {r_frame, r_count[OFF_W-1:0]};
            end
            lwpb_pkg::ST_FILL: begin
                frm_we    = r_lag_valid;
                frm_addr  = {r_frame, r_lag_off};
                frm_wdata = fill_byte;
            end
            lwpb_pkg::ST_ACCESS: begin
                frm_we = r_req_write;
                frm_re = !r_req_write;
            end
            lwpb_pkg::ST_RESPOND: begin
                frm_we = 1'b0;
            end
            default: begin
                frm_we = 1'b0;
            end
        endcase

        st_we    = (r_state == lwpb_pkg::ST_WRITEBACK) && r_lag_valid;
        st_waddr = {r_victim_page, r_lag_off};
        st_re    = (r_state == lwpb_pkg::ST_FILL) && !count_done;
        st_raddr = {r_page, r_count[OFF_W-1:0]};

        resp_rdata = (r_status == lwpb_pkg::STATUS_OK && !r_req_write) ? r_frame_rdata : '0;
    end

    // frame tags, dirty bits and recency ranks
    always_comb begin
        logic [FRAME_W-1:0] tf;
        tf        = hit_any ? hit_f : pick_f;
        n_valid   = r_valid;
        n_dirty   = r_dirty;
        n_recency = r_recency;
        n_fpage   = r_fpage;
        if (acc && !in_err) begin
            // age the valid frames that were more recent than the one touched
            for (int g = 0; g < NUM_FRAMES; g++) begin
                if ((FRAME_W'(g) != tf) && r_valid[g] &&
                    (!r_valid[tf] || (r_recency[g] < r_recency[tf]))) begin
                    n_recency[g] = r_recency[g] + REC_W'(1);
                end
            end
            n_recency[tf] = '0;
            if (hit_any) begin
                if (in_write) begin
                    n_dirty[tf] = 1'b1;
                end
            end else begin
                n_valid[tf] = 1'b1;
                n_dirty[tf] = 1'b0;
                n_fpage[tf] = in_page;
            end
        end
        if ((r_state == lwpb_pkg::ST_ACCESS) && r_req_write) begin
            n_dirty[r_frame] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= lwpb_pkg::ST_IDLE;
            r_array_size   <= lwpb_pkg::ARRAY_SIZE_RESET;
            r_valid        <= '0;
            r_dirty        <= '0;
            r_page_written <= '0;
            r_count        <= '0;
            r_lag_valid    <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int g = 0; g < NUM_FRAMES; g++) begin
                r_recency[g] <= '0;
                r_fpage[g]   <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_dirty   <= n_dirty;
            r_recency <= n_recency;
            r_fpage   <= n_fpage;
            if (i_cfg_valid) begin
                r_array_size <= i_cfg_data;
            end

            // copy sweep: issue one byte per cycle, write it in the following cycle
            if ((r_state == lwpb_pkg::ST_WRITEBACK) || (r_state == lwpb_pkg::ST_FILL)) begin
                r_lag_valid <= !count_done;
                r_count     <= count_done ? '0 : r_count + CNT_W'(1);
            end else begin
                r_lag_valid <= 1'b0;
                r_count     <= '0;
            end

            if ((r_state == lwpb_pkg::ST_WRITEBACK) && count_done) begin
                r_page_written[r_victim_page] <= 1'b1;
            end

            if ((r_state == lwpb_pkg::ST_RESPOND) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request payload and result register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req_write   <= in_write;
            r_offset      <= in_offset;
            r_page        <= in_page;
            r_wdata       <= in_wdata;
            r_frame       <= pick_f;
            r_victim_page <= r_fpage[pick_f];
            r_status      <= in_err ? lwpb_pkg::STATUS_RANGE : lwpb_pkg::STATUS_OK;
            r_hit         <= !in_err && hit_any;
        end
        r_lag_off <= r_count[OFF_W-1:0];
        if ((r_state == lwpb_pkg::ST_RESPOND) && out_free) begin
            r_out_data   <= {7'b0, r_hit, resp_rdata};
            r_out_status <= r_status;
        end
    end

    // frame memory: one port
    always_ff @(posedge i_clk) begin
        if (frm_we) begin
            mem_frame[frm_addr] <= frm_wdata;
        end
        if (frm_re) begin
            r_frame_rdata <= mem_frame[frm_addr];
        end
    end

    // backing store: one write port, one read port
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem_store[st_waddr] <= r_frame_rdata;
        end
        if (st_re) begin
            r_store_rdata <= mem_store[st_raddr];
        end
    end

endmodule
